// ===== rtl/core/pe_pkg.sv =====
// types, constants and helper functions shared across the percent encoder
package pe_pkg;

    // fixed field widths
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned TOTAL_W    = 18;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 4;

    // register reset value before truncation to the length width
    localparam logic [31:0] CFG_RESET_VALUE = 32'd65535;

    // register indexes, byte address bits [3:2]
    localparam logic [1:0] REG_SOURCE_LIMIT = 2'd0;
    localparam logic [1:0] REG_OUT_CAPACITY = 2'd1;
    localparam logic [1:0] REG_COUNT_ONLY   = 2'd2;

    // character codes and hex offsets
    localparam logic [7:0] CHAR_PERCENT  = 8'h25;
    localparam logic [7:0] CHAR_TERM     = 8'h00;
    localparam logic [7:0] HEX_DIGIT_OFS = 8'd48;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

    // input word
    typedef struct packed {
        logic [7:0] char_in;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [7:0]  char_out;
        logic        string_done;
        logic [17:0] total_size;
        logic        last;
    } t_out_word;

    // everything one source byte produces
    typedef struct packed {
        logic [2:0][7:0] chars;
        logic [1:0]      n_chars;
        logic            has_term;
        logic [17:0]     term_size;
    } t_plan;

    // unreserved set: letters, digits and - . _ ~
    function automatic logic is_unreserved(input logic [7:0] b);
        return b inside {[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39],
                         8'h2d, 8'h2e, 8'h5f, 8'h7e};
    endfunction

    // upper-case hex digit of one nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        return (nib > 4'd9) ? ({4'b0, nib} + HEX_ALPHA_OFS) : ({4'b0, nib} + HEX_DIGIT_OFS);
    endfunction

endpackage

// ===== rtl/core/pe_if.sv =====
// valid/ready stream channel carrying one word per handshake
interface pe_if #(
    parameter type t_data = logic [7:0]
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/percent_encoder.sv =====
// top level of the streaming url percent encoder
// Takes one source byte per word and sends out the encoded characters, then a
// terminator word with the string's total size (characters plus one) on the
// zero byte, at the source limit or when the next output would not fit the
// capacity. A byte goes through an input register and one pass of encode
// logic into a result buffer that holds up to four words. Unreserved bytes
// stream at one per cycle while the output is ready; an escaped byte holds
// the buffer until its three words and any terminator have drained at one
// word per cycle while the output is ready. Bytes that give no word (after
// an early stop) leave the buffer free. A byte passes the input register
// and the result buffer before it reaches the output. Registers are written
// through the apb-style port at byte addresses 0, 4 and 8 (source limit,
// output capacity, count-only) and should be written only while idle.
module percent_encoder #(
    parameter int unsigned LENGTH_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pe_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pe_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [pe_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                           pready,
    pe_if.sink                             i_in,
    pe_if.source                           o_out
);
    import pe_pkg::*;

    logic [LENGTH_WIDTH-1:0] w_source_limit;
    logic [LENGTH_WIDTH-1:0] w_out_capacity;
    logic                    w_count_only;
    logic                    r_a_valid;
    logic [7:0]              r_a_byte;
    logic                    w_load_ok;
    logic                    w_a_take;
    t_plan                   w_plan;
    t_in_word                w_in_word;

    // configuration registers
    pe_cfg #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_source_limit (w_source_limit),
        .o_out_capacity (w_out_capacity),
        .o_count_only   (w_count_only)
    );

    // input register
    assign w_in_word = i_in.data;
    assign w_a_take  = r_a_valid && w_load_ok;
    assign i_in.ready = !r_a_valid || w_a_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_a_valid <= 1'b1;
        end else if (w_a_take) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_a_byte <= w_in_word.char_in;
        end
    end

    // encode and string state
    pe_plan #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_plan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_a_take),
        .i_byte         (r_a_byte),
        .i_source_limit (w_source_limit),
        .i_out_capacity (w_out_capacity),
        .i_count_only   (w_count_only),
        .o_plan         (w_plan)
    );

    // result buffer
    pe_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (r_a_valid),
        .i_plan    (w_plan),
        .o_load_ok (w_load_ok),
        .o_out     (o_out)
    );

`ifndef ASSERT_OFF
    // no word is offered straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    // a held input byte is neither lost nor overwritten
    a_input_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !w_a_take |=> r_a_valid && $stable(r_a_byte))
        else $error("input register changed while waiting");
`endif
endmodule

// ===== rtl/core/pe_cfg.sv =====
// configuration registers behind the apb-style port
module pe_cfg #(
    parameter int unsigned LENGTH_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pe_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pe_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [pe_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                           pready,
    output logic [LENGTH_WIDTH-1:0]        o_source_limit,
    output logic [LENGTH_WIDTH-1:0]        o_out_capacity,
    output logic                           o_count_only
);
    import pe_pkg::*;

    localparam logic [LENGTH_WIDTH-1:0] LEN_RESET = LENGTH_WIDTH'(CFG_RESET_VALUE);

    logic [LENGTH_WIDTH-1:0] r_source_limit;
    logic [LENGTH_WIDTH-1:0] r_out_capacity;
    logic                    r_count_only;
    logic                    w_write;
    logic [1:0]              w_index;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_index = paddr[3:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_limit <= LEN_RESET;
            r_out_capacity <= LEN_RESET;
            r_count_only   <= 1'b0;
        end else if (w_write) begin
            case (w_index)
                REG_SOURCE_LIMIT: r_source_limit <= pwdata[LENGTH_WIDTH-1:0];
                REG_OUT_CAPACITY: r_out_capacity <= pwdata[LENGTH_WIDTH-1:0];
                REG_COUNT_ONLY:   r_count_only   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_index)
            REG_SOURCE_LIMIT: prdata = CFG_DATA_W'(r_source_limit);
            REG_OUT_CAPACITY: prdata = CFG_DATA_W'(r_out_capacity);
            REG_COUNT_ONLY:   prdata = CFG_DATA_W'(r_count_only);
            default:          prdata = '0;
        endcase
    end

    assign o_source_limit = r_source_limit;
    assign o_out_capacity = r_out_capacity;
    assign o_count_only   = r_count_only;
endmodule

// ===== rtl/core/pe_plan.sv =====
// string state and the single-pass encode of one source byte
module pe_plan #(
    parameter int unsigned LENGTH_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_fire,
    input  logic [7:0]              i_byte,
    input  logic [LENGTH_WIDTH-1:0] i_source_limit,
    input  logic [LENGTH_WIDTH-1:0] i_out_capacity,
    input  logic                    i_count_only,
    output pe_pkg::t_plan           o_plan
);
    import pe_pkg::*;

    localparam int unsigned PW = LENGTH_WIDTH + 2;

    logic [LENGTH_WIDTH-1:0] r_consumed, n_consumed;
    logic [PW-1:0]           r_produced, n_produced;
    logic                    r_stopped, n_stopped;

    logic                    w_plain;
    logic [PW-1:0]           w_need;
    logic [PW:0]             w_cap_sum;
    logic                    w_cap_fail;
    logic [PW-1:0]           w_prod_inc;
    logic [LENGTH_WIDTH-1:0] w_cons_inc;
    logic                    w_limit_hit;
    logic [PW-1:0]           w_size_base;
    logic [PW-1:0]           w_size_sum;

    // byte class and the capacity and limit checks
    assign w_plain     = is_unreserved(i_byte);
    assign w_need      = w_plain ? PW'(1) : PW'(3);
    assign w_cap_sum   = {1'b0, r_produced} + {1'b0, w_need} + (PW+1)'(1);
    assign w_cap_fail  = !i_count_only && (w_cap_sum > (PW+1)'(i_out_capacity));
    assign w_prod_inc  = r_produced + w_need;
    assign w_cons_inc  = r_consumed + LENGTH_WIDTH'(1);
    assign w_limit_hit = w_cons_inc >= i_source_limit;

    // decide the words and the next string state
    always_comb begin
        n_consumed      = r_consumed;
        n_produced      = r_produced;
        n_stopped       = r_stopped;
        w_size_base     = r_produced;
        o_plan          = '0;
        if (r_stopped) begin
            if (i_byte == CHAR_TERM) begin
                n_stopped = 1'b0;
            end
        end else if (i_byte == CHAR_TERM) begin
            o_plan.has_term = 1'b1;
            n_consumed      = '0;
            n_produced      = '0;
        end else if (w_cap_fail) begin
            o_plan.has_term = 1'b1;
            n_stopped       = 1'b1;
            n_consumed      = '0;
            n_produced      = '0;
        end else begin
            if (!i_count_only) begin
                if (w_plain) begin
                    o_plan.chars[0] = i_byte;
                    o_plan.n_chars  = 2'd1;
                end else begin
                    o_plan.chars[0] = CHAR_PERCENT;
                    o_plan.chars[1] = hex_digit(i_byte[7:4]);
                    o_plan.chars[2] = hex_digit(i_byte[3:0]);
                    o_plan.n_chars  = 2'd3;
                end
            end
            if (w_limit_hit) begin
                o_plan.has_term = 1'b1;
                w_size_base     = w_prod_inc;
                n_stopped       = 1'b1;
                n_consumed      = '0;
                n_produced      = '0;
            end else begin
                n_consumed = w_cons_inc;
                n_produced = w_prod_inc;
            end
        end
        w_size_sum       = w_size_base + PW'(1);
        o_plan.term_size = TOTAL_W'(w_size_sum);
    end

    // string state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_consumed <= '0;
            r_produced <= '0;
            r_stopped  <= 1'b0;
        end else if (i_fire) begin
            r_consumed <= n_consumed;
            r_produced <= n_produced;
            r_stopped  <= n_stopped;
        end
    end
endmodule

// ===== rtl/core/pe_emit.sv =====
// result buffer that hands out the words of one byte, one per cycle while the output is ready
module pe_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  pe_pkg::t_plan i_plan,
    output logic          o_load_ok,
    pe_if.source          o_out
);
    import pe_pkg::*;

    t_plan      r_plan;
    logic [1:0] r_pos;
    logic       r_busy;

    logic [2:0] w_count;
    logic [2:0] w_load_count;
    logic [1:0] w_last_pos;
    logic       w_take;
    logic       w_last_take;
    logic       w_is_char;
    t_out_word  w_word;

    // word count and position of the final word
    assign w_count      = {1'b0, r_plan.n_chars} + {2'b0, r_plan.has_term};
    assign w_load_count = {1'b0, i_plan.n_chars} + {2'b0, i_plan.has_term};
    assign w_last_pos   = 2'(w_count - 3'd1);
    assign w_take       = r_busy && o_out.ready;
    assign w_last_take  = w_take && (r_pos == w_last_pos);
    assign o_load_ok    = !r_busy || w_last_take;

    // buffer load and drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (i_load && o_load_ok) begin
            r_busy <= (w_load_count != 3'd0);
            r_pos  <= '0;
        end else if (w_last_take) begin
            r_busy <= 1'b0;
        end else if (w_take) begin
            r_pos  <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_load_ok) begin
            r_plan <= i_plan;
        end
    end

    // build the word at the current position
    assign w_is_char = r_pos < r_plan.n_chars;

    always_comb begin
        w_word = '0;
        if (w_is_char) begin
            case (r_pos)
                2'd0:    w_word.char_out = r_plan.chars[0];
                2'd1:    w_word.char_out = r_plan.chars[1];
                2'd2:    w_word.char_out = r_plan.chars[2];
                default: w_word.char_out = CHAR_TERM;
            endcase
            w_word.last = (r_pos == w_last_pos);
        end else begin
            w_word.char_out    = CHAR_TERM;
            w_word.string_done = 1'b1;
            w_word.total_size  = r_plan.term_size;
            w_word.last        = 1'b1;
        end
    end

    assign o_out.valid = r_busy;
    assign o_out.data  = w_word;
endmodule
